// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while rst is high.
`define GTPT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gtpt check failed");

// Property checked on every rising edge, reset included.
`define GTPT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gtpt check failed");

`endif

// ===== rtl/gtpt_pkg.sv =====
package gtpt_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int KEY_W = 32;
   localparam int COORD_W = 16;
   localparam int GEN_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);
   localparam logic [GEN_W-1:0] GEN_MAX = '1;

   localparam logic [1:0] MODE_NEW_FRAME = 2'd0;
   localparam logic [1:0] MODE_STORE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // Register select is address bit 2.
   localparam logic REG_ORIGIN_X = 1'b0;
   localparam logic REG_ORIGIN_Y = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HOME,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [GEN_W-1:0]          gen;
      logic [KEY_W-1:0]          key;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COORD_W-1:0]        w;
      logic [COORD_W-1:0]        h;
   } entry_type;

   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      if (s[COORD_W] != s[COORD_W-1]) begin
         sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         sat_add = s[COORD_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/gtpt_home.sv =====
module gtpt_home #(
   parameter int SLOTS = gtpt_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gtpt_pkg::KEY_W-1:0]    key,
   output logic                          done,
   output logic [$clog2(SLOTS)-1:0]      idx
);
   import gtpt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         // Home slot is the low key bits; ready at once.
         assign done = 1'b1;
         assign idx = key[IDX_W-1:0];
      end else begin : g_mod
         localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(SLOTS));
         localparam logic [IDX_W:0] SLOTS_W = (IDX_W + 1)'(SLOTS);

         logic [2*KEY_W-1:0] prod;
         logic [KEY_W-1:0]   quo_ff, quo_in;
         logic [IDX_W:0]     low_ff, low_in;
         logic [IDX_W:0]     rem_ff, rem_in;
         logic               stg1_ff, stg2_ff;

         // Reciprocal quotient is exact or one low, so the remainder stays
         // below 2*SLOTS and fits the low key bits; one subtract finishes it.
         always_comb begin
            prod = {{KEY_W{1'b0}}, key} * {{KEY_W{1'b0}}, RECIP};
            quo_in = prod[2*KEY_W-1:KEY_W];
            low_in = key[IDX_W:0];
            rem_in = low_ff - quo_ff[IDX_W:0] * SLOTS_W;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stg1_ff <= 1'b0;
               stg2_ff <= 1'b0;
            end else begin
               stg1_ff <= start;
               stg2_ff <= stg1_ff;
            end
            quo_ff <= quo_in;
            low_ff <= low_in;
            rem_ff <= rem_in;
         end

         assign done = stg2_ff;
         assign idx = (rem_ff >= SLOTS_W) ? IDX_W'(rem_ff - SLOTS_W) : rem_ff[IDX_W-1:0];
      end
   endgenerate

endmodule

// ===== rtl/generation_tagged_probe_table_top.sv =====
// Keyed rectangle store with linear probing and generation tags.
// Input channel req_*: one beat per operation (new frame, store, lookup),
// accepted when req_valid is high and req_stall is low. Result channel
// rsp_*: exactly one beat per accepted item, in order, held steady while
// rsp_stall is high. Origin registers are written over the csr_* port.
// All slots live in one single-port-per-side memory with a registered read.
// With SLOTS a power of two, a new frame goes from accept straight to
// the DONE state; a store or lookup passes HOME, then one CHECK per slot
// probed (1..SLOTS), one memory read per probe, then DONE. Items are
// taken one at a time: the next is accepted only back in IDLE.
// With SLOTS not a power of two the home slot comes from a two-stage
// reciprocal-multiply remainder unit, and HOME waits for its result.
// Reset runs a clearing pass that marks every slot stale; req_stall
// stays high during it. A new frame at generation 65535 runs the
// same pass after its result is loaded. While the receiver stalls, a
// finished result waits in the output register and the next item is held
// at the end of its probe until that register frees.
module generation_tagged_probe_table_top #(
   parameter int SLOTS = gtpt_pkg::SLOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic [gtpt_pkg::KEY_W-1:0]            req_key,
   input  logic signed [gtpt_pkg::COORD_W-1:0]   req_rect_x,
   input  logic signed [gtpt_pkg::COORD_W-1:0]   req_rect_y,
   input  logic [gtpt_pkg::COORD_W-1:0]          req_rect_w,
   input  logic [gtpt_pkg::COORD_W-1:0]          req_rect_h,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic signed [gtpt_pkg::COORD_W-1:0]   rsp_found_x,
   output logic signed [gtpt_pkg::COORD_W-1:0]   rsp_found_y,
   output logic [gtpt_pkg::COORD_W-1:0]          rsp_found_w,
   output logic [gtpt_pkg::COORD_W-1:0]          rsp_found_h,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gtpt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [gtpt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [gtpt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import gtpt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int PRB_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [PRB_W-1:0] LAST_PRB = PRB_W'(SLOTS - 1);

   state_type state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [IDX_W-1:0] idx_ff, idx_in, idx_nxt;
   logic [PRB_W-1:0] prb_ff, prb_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic wrap_ff, wrap_in;

   logic [1:0] res_status_ff, res_status_in;
   logic signed [COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [COORD_W-1:0] res_w_ff, res_w_in, res_h_ff, res_h_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COORD_W-1:0] rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;

   logic signed [COORD_W-1:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;

   entry_type mem [SLOTS];
   entry_type rd_ff;
   entry_type wr_data;
   logic wr_en, rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic home_start, home_done;
   logic [IDX_W-1:0] home_idx;
   logic cur_match, key_match, out_free, csr_write;

   gtpt_home #(.SLOTS(SLOTS)) u_home (
      .clock (clock),
      .reset (reset),
      .start (home_start),
      .key   (key_in),
      .done  (home_done),
      .idx   (home_idx)
   );

   assign idx_nxt = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign cur_match = (rd_ff.gen == gen_ff);
   assign key_match = (rd_ff.key == key_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      key_in = key_ff;
      x_in = x_ff;
      y_in = y_ff;
      w_in = w_ff;
      h_in = h_ff;
      idx_in = idx_ff;
      prb_in = prb_ff;
      gen_in = gen_ff;
      wrap_in = wrap_ff;
      res_status_in = res_status_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      res_w_in = res_w_ff;
      res_h_in = res_h_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_w_in = rsp_w_ff;
      rsp_h_in = rsp_h_ff;
      req_stall = 1'b1;
      home_start = 1'b0;
      wr_en = 1'b0;
      wr_data = '0;
      rd_en = 1'b0;
      rd_addr = idx_nxt;

      unique case (state_ff)
         ST_CLEAR: begin
            // Mark one slot stale per cycle.
            wr_en = 1'b1;
            idx_in = idx_nxt;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in = req_mode;
               key_in = req_key;
               x_in = sat_add(req_rect_x, origin_x_ff);
               y_in = sat_add(req_rect_y, origin_y_ff);
               w_in = req_rect_w;
               h_in = req_rect_h;
               prb_in = '0;
               res_status_in = STATUS_OK;
               res_x_in = '0;
               res_y_in = '0;
               res_w_in = '0;
               res_h_in = '0;
               case (req_mode) inside
                  MODE_NEW_FRAME: begin
                     if (gen_ff == GEN_MAX) begin
                        gen_in = GEN_INIT;
                        wrap_in = 1'b1;
                     end else begin
                        gen_in = gen_ff + GEN_W'(1);
                     end
                     state_in = ST_DONE;
                  end
                  MODE_STORE, MODE_LOOKUP: begin
                     home_start = 1'b1;
                     state_in = ST_HOME;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_HOME: begin
            rd_addr = home_idx;
            if (home_done) begin
               rd_en = 1'b1;
               idx_in = home_idx;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (mode_ff == MODE_STORE && (!cur_match || key_match)) begin
               wr_en = 1'b1;
               wr_data = '{gen: gen_ff, key: key_ff, x: x_ff, y: y_ff, w: w_ff, h: h_ff};
               state_in = ST_DONE;
            end else if (mode_ff == MODE_LOOKUP && !cur_match) begin
               res_status_in = STATUS_MISS;
               state_in = ST_DONE;
            end else if (mode_ff == MODE_LOOKUP && key_match) begin
               res_x_in = rd_ff.x;
               res_y_in = rd_ff.y;
               res_w_in = rd_ff.w;
               res_h_in = rd_ff.h;
               state_in = ST_DONE;
            end else if (prb_ff == LAST_PRB) begin
               res_status_in = (mode_ff == MODE_STORE) ? STATUS_FULL : STATUS_MISS;
               state_in = ST_DONE;
            end else begin
               // Advance to the next slot; its read overlaps this check.
               prb_in = prb_ff + PRB_W'(1);
               idx_in = idx_nxt;
               rd_en = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_x_in = res_x_ff;
               rsp_y_in = res_y_ff;
               rsp_w_in = res_w_ff;
               rsp_h_in = res_h_ff;
               idx_in = '0;
               wrap_in = 1'b0;
               state_in = wrap_ff ? ST_CLEAR : ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         prb_ff <= '0;
         gen_ff <= GEN_INIT;
         wrap_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         prb_ff <= prb_in;
         gen_ff <= gen_in;
         wrap_ff <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      key_ff <= key_in;
      x_ff <= x_in;
      y_ff <= y_in;
      w_ff <= w_in;
      h_ff <= h_in;
      res_status_ff <= res_status_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      res_w_ff <= res_w_in;
      res_h_ff <= res_h_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_w_ff <= rsp_w_in;
      rsp_h_ff <= rsp_h_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Configuration registers.
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      unique case (csr_paddr[2])
         REG_ORIGIN_X: begin
            csr_prdata = {{(CSR_DATA_W - COORD_W){1'b0}}, origin_x_ff};
            if (csr_write) origin_x_in = csr_pwdata[COORD_W-1:0];
         end
         REG_ORIGIN_Y: begin
            csr_prdata = {{(CSR_DATA_W - COORD_W){1'b0}}, origin_y_ff};
            if (csr_write) origin_y_in = csr_pwdata[COORD_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_x = rsp_x_ff;
   assign rsp_found_y = rsp_y_ff;
   assign rsp_found_w = rsp_w_ff;
   assign rsp_found_h = rsp_h_ff;

endmodule

// ===== rtl/gtpt_checker.sv =====
`include "assert_macros.svh"

module gtpt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [1:0]                           rsp_status,
   input logic signed [gtpt_pkg::COORD_W-1:0]  rsp_found_x,
   input logic signed [gtpt_pkg::COORD_W-1:0]  rsp_found_y,
   input logic [gtpt_pkg::COORD_W-1:0]         rsp_found_w,
   input logic [gtpt_pkg::COORD_W-1:0]         rsp_found_h
);
   import gtpt_pkg::*;

   logic found_zero;
   assign found_zero = (rsp_found_x == '0) && (rsp_found_y == '0) &&
                       (rsp_found_w == '0) && (rsp_found_h == '0);

   // Clearing pass follows reset, so no item is taken right after it.
   `GTPT_ASSERT_ALWAYS(a_stall_after_reset, clock, reset |=> req_stall)

   `GTPT_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_MISS || rsp_status == STATUS_FULL))

   // Miss and full carry no rectangle.
   `GTPT_ASSERT(a_miss_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK |-> found_zero)

   `GTPT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))

endmodule

bind generation_tagged_probe_table_top gtpt_checker u_gtpt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_status  (rsp_status),
   .rsp_found_x (rsp_found_x),
   .rsp_found_y (rsp_found_y),
   .rsp_found_w (rsp_found_w),
   .rsp_found_h (rsp_found_h)
);
